// File: src/lksc_pkg.sv
// Shared types and fixed widths for the LRU keyed slot cache.
package lksc_pkg;

    localparam int KEY_W  = 42;
    localparam int SLOT_W = 3;
    localparam int OCC_W  = 3;

    typedef logic [KEY_W-1:0] key_t;

    // Request broadcast to every cell.
    typedef struct packed {
        logic fire;
        logic trim;
        key_t key;
    } lksc_cmd_t;

    // Lookup outcome seen at the far end of the chain, fed back to all cells.
    typedef struct packed {
        logic any_hit;
        logic full;
    } lksc_bcast_t;

    // Priority flags that ripple from cell to cell.
    typedef struct packed {
        logic found;
        logic free;
    } lksc_chain_t;

endpackage

// File: src/lksc_cell.sv
// One cache entry: key, valid flag and age rank, with its link in the priority chain.
module lksc_cell
    import lksc_pkg::*;
#(
    parameter int ENTRIES = 6,
    parameter int KEEP    = 2,
    parameter int INDEX   = 0,
    localparam int RANK_W = $clog2(ENTRIES),
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lksc_cmd_t         cmd_i,
    input  lksc_bcast_t       bcast_i,
    input  logic [RANK_W-1:0] hit_rank_i,
    input  lksc_chain_t       chain_i,
    input  logic [RANK_W-1:0] rank_i,
    input  logic [IDX_W-1:0]  idx_i,
    output lksc_chain_t       chain_o,
    output logic [RANK_W-1:0] rank_o,
    output logic [IDX_W-1:0]  idx_o
);

    localparam int CMP_W = RANK_W + 4;

    key_t              key_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    logic my_hit;
    logic first_hit;
    logic first_free;
    logic victim;
    logic pick;
    logic old_enough;

    assign my_hit     = valid_reg && (key_reg == cmd_i.key);
    assign first_hit  = my_hit && !chain_i.found;
    assign first_free = !valid_reg && !chain_i.free;
    // When every slot is valid the ranks are exactly 0 .. ENTRIES-1.
    assign victim     = valid_reg && (rank_reg == RANK_W'(ENTRIES - 1));
    assign old_enough = ({4'b0000, rank_reg} >= CMP_W'(KEEP));

    always_comb begin
        if (bcast_i.any_hit) begin
            pick = first_hit;
        end else if (bcast_i.full) begin
            pick = victim;
        end else begin
            pick = first_free;
        end
    end

    assign chain_o.found = chain_i.found | my_hit;
    assign chain_o.free  = chain_i.free | !valid_reg;
    assign rank_o        = rank_i | (first_hit ? rank_reg : '0);
    assign idx_o         = idx_i | (pick ? IDX_W'(INDEX) : '0);

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd_i.fire) begin
            if (cmd_i.trim) begin
                if (valid_reg && old_enough) begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
            end else if (bcast_i.any_hit) begin
                if (first_hit) begin
                    rank_next = '0;
                end else if (valid_reg && (rank_reg < hit_rank_i)) begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end else if (pick) begin
                valid_next = 1'b1;
                rank_next  = '0;
            end else if (valid_reg) begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.fire && !cmd_i.trim && !bcast_i.any_hit && pick) begin
            key_reg <= cmd_i.key;
        end
    end

endmodule

// File: src/lru_keyed_slot_cache_top.sv
// Top level of the LRU keyed slot cache: request handshake, cell chain and result register.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    req_type, five key bytes, resolution
//   m_        out   m_valid/m_ready    hit, slot, replaced, occupancy
//
// Each request is decided in the cycle it is accepted, one per cycle unless the output stalls;
// the path that sets this is the key compare in every cell followed by the ripple through the chain.
// The result appears in the output register on the next cycle.
// Reset clears all valid flags and ranks at once; no clearing pass is needed.
// A stalled result holds the output register, and a new request is taken in the
// same cycle that the waiting result is taken.
module lru_keyed_slot_cache_top
    import lksc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 6,
    parameter int TRIM_KEEP     = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_shirt_style,
    input  logic [7:0] s_shirt_colour,
    input  logic [7:0] s_stripe_colour,
    input  logic [7:0] s_shorts_colour,
    input  logic [7:0] s_socks_colour,
    input  logic [1:0] s_resolution,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_hit,
    output logic [2:0] m_slot,
    output logic       m_replaced,
    output logic [2:0] m_occupancy
);

    localparam int RANK_W = $clog2(CACHE_ENTRIES);
    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);

    lksc_cmd_t   cmd;
    lksc_bcast_t bcast;

    lksc_chain_t       chain_c [CACHE_ENTRIES+1];
    logic [RANK_W-1:0] rank_c  [CACHE_ENTRIES+1];
    logic [IDX_W-1:0]  idx_c   [CACHE_ENTRIES+1];

    logic             out_valid_reg;
    logic             hit_reg;
    logic [2:0]       slot_reg;
    logic             replaced_reg;
    logic [2:0]       occ_out_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    logic [SLOT_W+IDX_W-1:0] slot_wide;
    logic [OCC_W+CNT_W-1:0]  occ_wide;

    assign s_ready = !out_valid_reg || m_ready;

    assign cmd.fire = s_valid && s_ready;
    assign cmd.trim = s_req_type;
    assign cmd.key  = {s_shirt_style, s_shirt_colour, s_stripe_colour,
                       s_shorts_colour, s_socks_colour, s_resolution};

    assign chain_c[0] = '{found: 1'b0, free: 1'b0};
    assign rank_c[0]  = '0;
    assign idx_c[0]   = '0;

    assign bcast.any_hit = chain_c[CACHE_ENTRIES].found;
    assign bcast.full    = !chain_c[CACHE_ENTRIES].free;

    for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
        lksc_cell #(
            .ENTRIES (CACHE_ENTRIES),
            .KEEP    (TRIM_KEEP),
            .INDEX   (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd_i      (cmd),
            .bcast_i    (bcast),
            .hit_rank_i (rank_c[CACHE_ENTRIES]),
            .chain_i    (chain_c[i]),
            .rank_i     (rank_c[i]),
            .idx_i      (idx_c[i]),
            .chain_o    (chain_c[i+1]),
            .rank_o     (rank_c[i+1]),
            .idx_o      (idx_c[i+1])
        );
    end

    // Ranks of valid entries are distinct and dense, so a trim keeps min(count, keep).
    always_comb begin
        occ_next = occ_reg;
        if (cmd.trim) begin
            if ({4'b0000, occ_reg} > (CNT_W + 4)'(TRIM_KEEP)) begin
                occ_next = CNT_W'(TRIM_KEEP);
            end
        end else if (!bcast.any_hit && !bcast.full) begin
            occ_next = occ_reg + CNT_W'(1);
        end
    end

    assign slot_wide = {{SLOT_W{1'b0}}, idx_c[CACHE_ENTRIES]};
    assign occ_wide  = {{OCC_W{1'b0}}, occ_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end else begin
            if (cmd.fire) begin
                out_valid_reg <= 1'b1;
                occ_reg       <= occ_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            hit_reg      <= !cmd.trim && bcast.any_hit;
            slot_reg     <= cmd.trim ? '0 : slot_wide[SLOT_W-1:0];
            replaced_reg <= !cmd.trim && !bcast.any_hit && bcast.full;
            occ_out_reg  <= occ_wide[OCC_W-1:0];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_hit       = hit_reg;
    assign m_slot      = slot_reg;
    assign m_replaced  = replaced_reg;
    assign m_occupancy = occ_out_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(CACHE_ENTRIES))
        else $error("occupancy count exceeds the number of entries");

    a_hit_not_replaced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_replaced))
        else $error("a result reports both a hit and an eviction");

    a_trim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire && cmd.trim) |=> ({4'b0000, occ_reg} <= (CNT_W + 4)'(TRIM_KEEP)))
        else $error("trim left more entries than it should keep");

    a_free_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire && !cmd.trim && !bcast.any_hit && !bcast.full)
            |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("install into a free slot did not grow the occupancy");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        bcast.full |-> (occ_reg == CNT_W'(CACHE_ENTRIES)))
        else $error("cells report full while the count disagrees");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU keyed slot cache with a recency predictor and random stalls.
module tb_top
    import lksc_pkg::*;
;

    localparam int ENTRIES         = 6;
    localparam int KEEP            = 2;
    localparam int RANDOM_REQUESTS = 800;
    localparam int POOL_SIZE       = 10;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum bit {
        REQ_LOOKUP = 1'b0,
        REQ_TRIM   = 1'b1
    } req_kind_e;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SLOW,
        SINK_TOGGLE
    } sink_mode_e;

    // Field order below the kind matches the packed key, high byte first.
    typedef struct packed {
        req_kind_e  kind;
        logic [7:0] shirt_style;
        logic [7:0] shirt_colour;
        logic [7:0] stripe_colour;
        logic [7:0] shorts_colour;
        logic [7:0] socks_colour;
        logic [1:0] resolution;
    } cache_req_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic       replaced;
        logic [2:0] occupancy;
    } cache_result_t;

    class cache_scoreboard;
        key_t          keys[ENTRIES];
        bit            live[ENTRIES];
        int            rank[ENTRIES];
        cache_result_t expected[$];
        int            errors;
        int unsigned   accepted;

        // Every live entry younger than the given rank moves one step older.
        function void age_ranks(int limit);
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && rank[i] < limit)
                    rank[i]++;
        endfunction

        function cache_result_t apply_request(cache_req_t r);
            cache_result_t res;
            key_t          key;
            bit            found;
            bit            have_free;
            int            pick;
            int            oldest;
            int            count;
            res = '0;
            pick = 0;
            if (r.kind == REQ_TRIM) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (live[i] && rank[i] >= KEEP) begin
                        live[i] = 1'b0;
                        rank[i] = 0;
                    end
            end else begin
                key = {r.shirt_style, r.shirt_colour, r.stripe_colour,
                       r.shorts_colour, r.socks_colour, r.resolution};
                found = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                    if (!found && live[i] && keys[i] == key) begin
                        found = 1'b1;
                        pick = i;
                    end
                if (found) begin
                    age_ranks(rank[pick]);
                    rank[pick] = 0;
                    res.hit = 1'b1;
                end else begin
                    have_free = 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!have_free && !live[i]) begin
                            have_free = 1'b1;
                            pick = i;
                        end
                    if (!have_free) begin
                        // Full: the entry with the largest age rank is evicted.
                        oldest = 0;
                        for (int i = 0; i < ENTRIES; i++)
                            if (rank[i] >= oldest) begin
                                oldest = rank[i];
                                pick = i;
                            end
                        live[pick] = 1'b0;
                        res.replaced = 1'b1;
                    end
                    age_ranks(ENTRIES);
                    keys[pick] = key;
                    live[pick] = 1'b1;
                    rank[pick] = 0;
                end
                res.slot = 3'(pick);
            end
            count = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (live[i])
                    count++;
            res.occupancy = 3'(count);
            return res;
        endfunction

        function void note_request(cache_req_t r);
            expected.push_back(apply_request(r));
            accepted++;
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (expected.size() == 0) begin
                $display("%0t: result with no request outstanding: hit %0d slot %0d",
                         $time, got.hit, got.slot);
                errors++;
                return;
            end
            want = expected[0];
            expected.delete(0);
            compare_field("hit", 3'(want.hit), 3'(got.hit));
            compare_field("slot", want.slot, got.slot);
            compare_field("replaced", 3'(want.replaced), 3'(got.replaced));
            compare_field("occupancy", want.occupancy, got.occupancy);
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic       s_req_type      = 1'b0;
    logic [7:0] s_shirt_style   = 8'h00;
    logic [7:0] s_shirt_colour  = 8'h00;
    logic [7:0] s_stripe_colour = 8'h00;
    logic [7:0] s_shorts_colour = 8'h00;
    logic [7:0] s_socks_colour  = 8'h00;
    logic [1:0] s_resolution    = 2'd0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_hit;
    logic [2:0] m_slot;
    logic       m_replaced;
    logic [2:0] m_occupancy;

    cache_scoreboard sb = new();

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lru_keyed_slot_cache_top #(
        .CACHE_ENTRIES(ENTRIES),
        .TRIM_KEEP    (KEEP)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_shirt_style  (s_shirt_style),
        .s_shirt_colour (s_shirt_colour),
        .s_stripe_colour(s_stripe_colour),
        .s_shorts_colour(s_shorts_colour),
        .s_socks_colour (s_socks_colour),
        .s_resolution   (s_resolution),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_slot         (m_slot),
        .m_replaced     (m_replaced),
        .m_occupancy    (m_occupancy)
    );

    // Results are checked before the request taken at the same edge is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result({m_hit, m_slot, m_replaced, m_occupancy});
            if (s_valid && s_ready)
                sb.note_request({s_req_type, s_shirt_style, s_shirt_colour,
                                 s_stripe_colour, s_shorts_colour, s_socks_colour,
                                 s_resolution});
        end
    end

    function automatic cache_req_t make_req(req_kind_e kind, key_t key);
        return {kind, key};
    endfunction

    function automatic key_t random_key();
        return key_t'({$urandom(), $urandom()});
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_request(input cache_req_t r);
        s_valid         <= 1'b1;
        s_req_type      <= r.kind;
        s_shirt_style   <= r.shirt_style;
        s_shirt_colour  <= r.shirt_colour;
        s_stripe_colour <= r.stripe_colour;
        s_shorts_colour <= r.shorts_colour;
        s_socks_colour  <= r.socks_colour;
        s_resolution    <= r.resolution;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    initial begin : stimulus
        key_t       pool[POOL_SIZE];
        cache_req_t req;
        int         burst_left;
        int         span;
        int         roll;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(make_req(REQ_TRIM, '0));
        send_request(make_req(REQ_LOOKUP, '0));
        send_request(make_req(REQ_LOOKUP, '1));
        send_request(make_req(REQ_LOOKUP, '0));
        send_request(make_req(REQ_TRIM, '1));
        send_request(make_req(REQ_LOOKUP, {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 2'd1}));
        send_request(make_req(REQ_LOOKUP, {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 2'd2}));
        // Same bytes as the all-zero key, different resolution.
        send_request(make_req(REQ_LOOKUP, {40'h0, 2'd1}));
        send_request(make_req(REQ_LOOKUP, {8'hFF, 32'h0, 2'd0}));
        send_request(make_req(REQ_LOOKUP, '1));
        send_request(make_req(REQ_LOOKUP, {8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 2'd3}));
        send_request(make_req(REQ_LOOKUP, {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 2'd2}));
        send_request(make_req(REQ_LOOKUP, '1));
        send_request(make_req(REQ_LOOKUP, {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 2'd1}));
        send_request(make_req(REQ_TRIM, '0));
        send_request(make_req(REQ_LOOKUP, {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 2'd2}));
        send_request(make_req(REQ_LOOKUP, {40'h12_34_56_78_9A, 2'd0}));
        send_request(make_req(REQ_LOOKUP, '0));
        send_request(make_req(REQ_TRIM, '0));
        send_request(make_req(REQ_LOOKUP, '1));

        // A small pool of keys that shifts over time keeps hits, fills and
        // evictions all common; the span limits how many keys are in play.
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = random_key();
        burst_left = 0;
        span = POOL_SIZE;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (burst_left == 0) begin
                roll = $urandom_range(0, 9);
                burst_left = (roll == 0) ? 80 : $urandom_range(1, 20);
                span = $urandom_range(3, POOL_SIZE);
                if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            burst_left--;
            if ($urandom_range(0, 19) == 0)
                pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
            roll = $urandom_range(0, 99);
            if (roll < 8)
                req = make_req(REQ_TRIM, random_key());
            else if (roll < 18)
                req = make_req(REQ_LOOKUP, random_key());
            else
                req = make_req(REQ_LOOKUP, pool[$urandom_range(0, span - 1)]);
            send_request(req);
        end
        s_valid <= 1'b0;
        // The last request is noted at its accepting edge, so wait on the clock before polling.
        @(posedge aclk);

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // The result side stalls in stretches of varying style, and once holds off
    // long enough for the block to back up into its request side.
    initial begin : result_sink
        sink_mode_e mode;
        int         stretch;
        bit         held;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && sb.accepted >= HOLD_AT) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            mode = sink_mode_e'($urandom_range(0, 3));
            stretch = $urandom_range(8, 40);
            for (int c = 0; c < stretch; c++) begin
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= c[0];
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule
